@@ hw/rtl/pmm_pkg.sv @@
// Types and codes shared by the paged memory mapper.
// No dependencies.
`default_nettype none

package pmm_pkg;

  localparam int unsigned MapEntries = 256;
  localparam int unsigned IdxW       = $clog2(MapEntries);

  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_MAP_BANK  = 2'd1,
    CMD_FIND      = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  localparam logic [1:0] TYPE_RAM = 2'd1;
  localparam logic [1:0] TYPE_ROM = 2'd2;

  typedef enum logic [1:0] {
    CFG_BUS_WIDTH = 2'd0,
    CFG_RAM_SIZE  = 2'd1,
    CFG_ROM_SIZE  = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] cpu_address;
    logic [7:0]  start_page;
    logic [1:0]  mem_type;
    logic [15:0] bank_number;
    logic [4:0]  size_log2;
    logic [31:0] full_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  page_type;
    logic [15:0] page_number;
    logic [31:0] abs_address;
    logic [21:0] store_offset;
    logic [23:0] found_address;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] page;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/paged_memory_mapper.sv @@
// Paged memory mapper: 256-entry page map with translate, map bank and find.
// Depends on pmm_pkg for item types and codes.
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall pmm_pkg::req_t
//  rsp      out        rsp_valid/rsp_stall pmm_pkg::rsp_t
//  cfg      in         cfg_valid/cfg_ready cfg_index (2b), cfg_data (5b)
//
// One item at a time; req_stall is high from acceptance until the result is
// handed to the output register. Translate uses S_TRD and S_TCALC; map bank
// writes 2^k entries, one map write a cycle; find scans, one map read a cycle
// through the single read port. Command 3 and rejected banks go to S_DONE.
// Synchronous reset clears the map's valid bits at once; no clearing pass.
// A result held in rsp under rsp_stall does not block taking the next item.
`default_nettype none

module paged_memory_mapper (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire pmm_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output pmm_pkg::rsp_t      rsp,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [4:0]    cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TRD   = 6'b000010,
    S_TCALC = 6'b000100,
    S_MAP   = 6'b001000,
    S_FIND  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam int unsigned IdxW = pmm_pkg::IdxW;

  state_t          state;
  pmm_pkg::req_t   item;
  pmm_pkg::rsp_t   res;
  logic [4:0]      bus_width;
  logic [4:0]      ram_size_log2;
  logic [4:0]      rom_size_log2;

  pmm_pkg::entry_t mem [pmm_pkg::MapEntries];
  logic [pmm_pkg::MapEntries-1:0] valid;
  pmm_pkg::entry_t rd_data;
  logic            rd_vld;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;

  logic [IdxW-1:0] wr_addr;
  logic [15:0]     wr_page;
  logic [IdxW:0]   wleft;
  logic [IdxW:0]   fcnt;
  logic            cmp_valid;
  logic [IdxW-1:0] cmp_idx;

  logic            acc;
  logic [4:0]      bw_c, ram_c, rom_c, sh, pgl, k;
  logic [23:0]     pm, busmask, addr_m;
  logic [IdxW-1:0] t_idx;
  logic            too_large;
  logic [IdxW:0]   cnt;
  logic [15:0]     num;
  pmm_pkg::entry_t eff;
  logic [31:0]     base, want;
  logic [21:0]     ram_mask, rom_mask, off;
  logic            cmp_hit;
  logic [23:0]     found;

  assign acc       = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    bw_c  = (bus_width < 5'd8) ? 5'd8 : ((bus_width > 5'd24) ? 5'd24 : bus_width);
    ram_c = (ram_size_log2 < 5'd8) ? 5'd8 :
            ((ram_size_log2 > 5'd22) ? 5'd22 : ram_size_log2);
    rom_c = (rom_size_log2 < 5'd8) ? 5'd8 :
            ((rom_size_log2 > 5'd19) ? 5'd19 : rom_size_log2);
    sh       = (bw_c > 5'd16) ? bw_c - 5'd8 : 5'd8;
    pgl      = bw_c - 5'd8;
    pm       = ~(24'hffffff << pgl);
    busmask  = ~(24'hffffff << bw_c);
    addr_m   = item.cpu_address & busmask;
    t_idx    = IdxW'(addr_m >> sh);
    k         = (req.size_log2 > pgl) ? req.size_log2 - pgl : 5'd0;
    too_large = (k > 5'd8);
    cnt       = (IdxW+1)'(1) << k[3:0];
    num       = req.bank_number << k[3:0];
    eff      = rd_vld ? rd_data : '0;
    base     = {16'd0, eff.page} << sh;
    ram_mask = ~(22'h3fffff << ram_c);
    rom_mask = ~(22'h3fffff << rom_c);
    case (eff.kind)
      pmm_pkg::TYPE_RAM: off = base[21:0] & ram_mask;
      pmm_pkg::TYPE_ROM: off = base[21:0] & rom_mask;
      default:           off = '0;
    endcase
    want    = item.full_address >> sh;
    cmp_hit = (eff.kind == item.mem_type) && (want[31:16] == 16'd0) &&
              (eff.page == want[15:0]);
    found   = ({16'd0, cmp_idx} << sh) | (item.full_address[23:0] & pm);
    rd_en   = (state == S_TRD) || ((state == S_FIND) && !fcnt[IdxW]);
    rd_addr = (state == S_FIND) ? fcnt[IdxW-1:0] : t_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_width     <= 5'd16;
      ram_size_log2 <= 5'd17;
      rom_size_log2 <= 5'd14;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmm_pkg::CFG_BUS_WIDTH: bus_width     <= cfg_data;
        pmm_pkg::CFG_RAM_SIZE:  ram_size_log2 <= cfg_data;
        pmm_pkg::CFG_ROM_SIZE:  rom_size_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MAP) begin
      mem[wr_addr] <= '{kind: item.mem_type, page: wr_page};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (state == S_MAP) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cmp_valid <= 1'b0;
      fcnt      <= '0;
      wleft     <= '0;
    end else begin
      cmp_valid <= (state == S_FIND) && !fcnt[IdxW];
      cmp_idx   <= fcnt[IdxW-1:0];
      if ((state == S_DONE) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            item <= req;
            fcnt <= '0;
            case (req.cmd)
              pmm_pkg::CMD_TRANSLATE: state <= S_TRD;
              pmm_pkg::CMD_MAP_BANK: begin
                if (too_large) begin
                  res   <= '{status: pmm_pkg::ST_TOO_LARGE, default: '0};
                  state <= S_DONE;
                end else begin
                  res     <= '0;
                  wr_addr <= req.start_page;
                  wr_page <= num;
                  wleft   <= cnt;
                  state   <= S_MAP;
                end
              end
              pmm_pkg::CMD_FIND: state <= S_FIND;
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_TRD: state <= S_TCALC;
        S_TCALC: begin
          res   <= '{status:        pmm_pkg::ST_OK,
                     page_type:     eff.kind,
                     page_number:   eff.page,
                     abs_address:   base | {8'd0, addr_m & pm},
                     store_offset:  off,
                     found_address: '0};
          state <= S_DONE;
        end
        S_MAP: begin
          wr_addr <= wr_addr + 1'b1;
          wr_page <= wr_page + 16'd1;
          wleft   <= wleft - 1'b1;
          if (wleft == (IdxW+1)'(1)) begin
            state <= S_DONE;
          end
        end
        S_FIND: begin
          if (!fcnt[IdxW]) begin
            fcnt <= fcnt + 1'b1;
          end
          if (cmp_valid && cmp_hit) begin
            res   <= '{status: pmm_pkg::ST_OK, found_address: found, default: '0};
            state <= S_DONE;
          end else if (cmp_valid && (cmp_idx == IdxW'(pmm_pkg::MapEntries - 1))) begin
            res   <= '{status: pmm_pkg::ST_NOT_FOUND, default: '0};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    acc |=> req_stall)
    else $error("block not busy after accepting an item");

  a_hold_when_out_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_valid && rsp_stall) |=> state == S_DONE)
    else $error("result released while output register full");

  a_find_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND && cmp_valid && cmp_hit) |=>
      (state == S_DONE && res.status == pmm_pkg::ST_OK))
    else $error("find hit did not produce an ok result");

  a_map_count_live: assert property (@(posedge clk) disable iff (rst)
    state == S_MAP |-> wleft != '0)
    else $error("map write with no entries left");

  a_reject_no_write: assert property (@(posedge clk) disable iff (rst)
    (acc && req.cmd == pmm_pkg::CMD_MAP_BANK && too_large) |=>
      (state == S_DONE && res.status == pmm_pkg::ST_TOO_LARGE))
    else $error("oversized bank not rejected");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for paged_memory_mapper (depends on pmm_pkg): a
// directed stimulus table, then random traffic over several register settings
// and idling phases; each result checked by a page-map predictor or its row.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] TYPE_NONE  = 2'd0;
  localparam logic [1:0] TYPE_OTHER = 2'd3;

  typedef struct {
    pmm_pkg::req_t item;
    pmm_pkg::rsp_t want;
    bit            typed;
  } dir_row_t;

  typedef struct {
    logic [4:0]  bus_width;
    logic [4:0]  ram_log2;
    logic [4:0]  rom_log2;
    int unsigned idle_pct;
    int unsigned stall_pct;
  } phase_t;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  pmm_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  pmm_pkg::rsp_t rsp;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [4:0]    cfg_data;

  logic [1:0]    map_kind [pmm_pkg::MapEntries];
  logic [15:0]   map_page [pmm_pkg::MapEntries];
  logic [4:0]    bus_width_r;
  logic [4:0]    ram_log2_r;
  logic [4:0]    rom_log2_r;
  pmm_pkg::rsp_t rsp_due_q [$];
  int unsigned   mismatches     = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_left      = 0;
  bit            hold_request   = 1'b0;
  bit            item_typed     = 1'b0;
  pmm_pkg::rsp_t item_typed_rsp = '0;

  paged_memory_mapper i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned eff_width();
    return clamp(32'(bus_width_r), 8, 24);
  endfunction

  function automatic int unsigned page_shift();
    return (eff_width() > 16) ? eff_width() - 8 : 8;
  endfunction

  function automatic pmm_pkg::rsp_t mapper_step(input pmm_pkg::req_t r);
    pmm_pkg::rsp_t o;
    int unsigned   bw, sh, low_mask, addr, idx, k, num, slot, want, n;
    logic [31:0]   base;
    o = '0;
    bw = eff_width();
    sh = page_shift();
    low_mask = (32'd1 << (bw - 8)) - 1;
    case (r.cmd)
      pmm_pkg::CMD_TRANSLATE: begin
        addr = 32'(r.cpu_address) & ((32'd1 << bw) - 1);
        idx = (addr >> sh) & (pmm_pkg::MapEntries - 1);
        base = 32'(map_page[idx]) << sh;
        o.page_type = map_kind[idx];
        o.page_number = map_page[idx];
        o.abs_address = base | (addr & low_mask);
        if (map_kind[idx] == pmm_pkg::TYPE_RAM) begin
          o.store_offset = 22'(base & ((32'd1 << clamp(32'(ram_log2_r), 8, 22)) - 1));
        end else if (map_kind[idx] == pmm_pkg::TYPE_ROM) begin
          o.store_offset = 22'(base & ((32'd1 << clamp(32'(rom_log2_r), 8, 19)) - 1));
        end
      end
      pmm_pkg::CMD_MAP_BANK: begin
        k = (32'(r.size_log2) > bw - 8) ? 32'(r.size_log2) - (bw - 8) : 0;
        if (k > 8) begin
          o.status = pmm_pkg::ST_TOO_LARGE;
        end else begin
          num = 32'(r.bank_number) << k;
          slot = 32'(r.start_page);
          for (n = 0; n < (32'd1 << k); n++) begin
            map_kind[slot] = r.mem_type;
            map_page[slot] = 16'(num);
            slot = (slot + 1) % pmm_pkg::MapEntries;
            num = num + 1;
          end
        end
      end
      pmm_pkg::CMD_FIND: begin
        want = r.full_address >> sh;
        o.status = pmm_pkg::ST_NOT_FOUND;
        for (n = 0; n < pmm_pkg::MapEntries; n++) begin
          if (map_kind[n] == r.mem_type && 32'(map_page[n]) == want) begin
            o.status = pmm_pkg::ST_OK;
            o.found_address = 24'((n << sh) | (r.full_address & low_mask));
            break;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic pmm_pkg::req_t mk(input pmm_pkg::cmd_t c, input logic [23:0] cpu,
                                       input logic [7:0] first, input logic [1:0] kind,
                                       input logic [15:0] bank, input logic [4:0] slog,
                                       input logic [31:0] addr);
    pmm_pkg::req_t r;
    r.cmd = c;
    r.cpu_address = cpu;
    r.start_page = first;
    r.mem_type = kind;
    r.bank_number = bank;
    r.size_log2 = slog;
    r.full_address = addr;
    return r;
  endfunction

  function automatic pmm_pkg::req_t random_item();
    pmm_pkg::req_t r;
    logic [95:0]   noise;
    int unsigned   pick, slot, sh;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(pmm_pkg::req_t)-1:0];
    sh = page_shift();
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.cmd = pmm_pkg::CMD_TRANSLATE;
    end else if (pick < 65) begin
      r.cmd = pmm_pkg::CMD_MAP_BANK;
      if ($urandom_range(9) != 0) r.size_log2 = 5'(eff_width() - 8 + $urandom_range(3));
    end else if (pick < 85) begin
      slot = $urandom_range(pmm_pkg::MapEntries - 1);
      r.cmd = pmm_pkg::CMD_FIND;
      r.mem_type = map_kind[slot];
      r.full_address = (32'(map_page[slot]) << sh) | (r.full_address & ((32'd1 << sh) - 1));
    end else if (pick < 95) begin
      r.cmd = pmm_pkg::CMD_FIND;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= 200) $display("mismatch: %s got %0h expected %0h", what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk) begin
    pmm_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due_q.size() == 0) begin
          report("result with none outstanding", 32'(rsp.status), 0);
        end else begin
          want = rsp_due_q.pop_front();
          check_field("status", 32'(rsp.status), 32'(want.status));
          check_field("page_type", 32'(rsp.page_type), 32'(want.page_type));
          check_field("page_number", 32'(rsp.page_number), 32'(want.page_number));
          check_field("abs_address", rsp.abs_address, want.abs_address);
          check_field("store_offset", 32'(rsp.store_offset), 32'(want.store_offset));
          check_field("found_address", 32'(rsp.found_address), 32'(want.found_address));
        end
      end
      if (req_valid && !req_stall) begin
        want = mapper_step(req);
        rsp_due_q.push_back(item_typed ? item_typed_rsp : want);
      end
    end
  end

  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic offer(input pmm_pkg::req_t item, input bit typed,
                       input pmm_pkg::rsp_t typed_rsp);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    item_typed = typed;
    item_typed_rsp = typed_rsp;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic write_reg(input pmm_pkg::cfg_index_t idx, input logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pmm_pkg::CFG_BUS_WIDTH: bus_width_r = val;
      pmm_pkg::CFG_RAM_SIZE:  ram_log2_r = val;
      pmm_pkg::CFG_ROM_SIZE:  rom_log2_r = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (rsp_due_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    dir_row_t      dir_rows [$];
    phase_t        phases [$];
    pmm_pkg::req_t r;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = pmm_pkg::CFG_BUS_WIDTH;
    cfg_data = '0;
    foreach (map_kind[n]) begin
      map_kind[n] = TYPE_NONE;
      map_page[n] = '0;
    end
    bus_width_r = 5'd16;
    ram_log2_r = 5'd17;
    rom_log2_r = 5'd14;

    dir_rows.push_back('{mk(pmm_pkg::CMD_TRANSLATE, 24'h0, 8'h0, TYPE_NONE, 16'h0, 5'd8,
                            32'h0), '0, 1'b1});
    dir_rows.push_back('{mk(pmm_pkg::CMD_TRANSLATE, 24'hFFFFFF, 8'h0, TYPE_NONE, 16'h0, 5'd8,
                            32'h0),
                         pmm_pkg::rsp_t'{pmm_pkg::ST_OK, 2'd0, 16'd0, 32'hFF, 22'd0, 24'd0},
                         1'b1});
    dir_rows.push_back('{mk(pmm_pkg::CMD_FIND, 24'h0, 8'h0, TYPE_NONE, 16'h0, 5'd8, 32'hAB),
                         pmm_pkg::rsp_t'{pmm_pkg::ST_OK, 2'd0, 16'd0, 32'd0, 22'd0, 24'hAB},
                         1'b1});
    dir_rows.push_back('{mk(pmm_pkg::CMD_FIND, 24'h0, 8'h0, pmm_pkg::TYPE_RAM, 16'h0, 5'd8,
                            32'hFFFFFFFF),
                         pmm_pkg::rsp_t'{pmm_pkg::ST_NOT_FOUND, 2'd0, 16'd0, 32'd0, 22'd0,
                                         24'd0}, 1'b1});
    dir_rows.push_back('{mk(pmm_pkg::CMD_UNUSED, 24'hFFFFFF, 8'hFF, TYPE_OTHER, 16'hFFFF,
                            5'd31, 32'hFFFFFFFF), '0, 1'b1});
    dir_rows.push_back('{mk(pmm_pkg::CMD_MAP_BANK, 24'h0, 8'h0, pmm_pkg::TYPE_RAM, 16'h1,
                            5'd17, 32'h0),
                         pmm_pkg::rsp_t'{pmm_pkg::ST_TOO_LARGE, 2'd0, 16'd0, 32'd0, 22'd0,
                                         24'd0}, 1'b1});
    dir_rows.push_back('{mk(pmm_pkg::CMD_MAP_BANK, 24'hFFFFFF, 8'hFF, TYPE_OTHER, 16'hFFFF,
                            5'd31, 32'hFFFFFFFF),
                         pmm_pkg::rsp_t'{pmm_pkg::ST_TOO_LARGE, 2'd0, 16'd0, 32'd0, 22'd0,
                                         24'd0}, 1'b1});
    dir_rows.push_back('{mk(pmm_pkg::CMD_MAP_BANK, 24'h0, 8'h10, pmm_pkg::TYPE_RAM, 16'h3,
                            5'd12, 32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_TRANSLATE, 24'h1234, 8'h0, TYPE_NONE, 16'h0, 5'd8,
                            32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_MAP_BANK, 24'h0, 8'hFE, pmm_pkg::TYPE_ROM, 16'hFFFF,
                            5'd10, 32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_TRANSLATE, 24'hFF80, 8'h0, TYPE_NONE, 16'h0, 5'd8,
                            32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_TRANSLATE, 24'h0156, 8'h0, TYPE_NONE, 16'h0, 5'd8,
                            32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_FIND, 24'h0, 8'h0, pmm_pkg::TYPE_ROM, 16'h0, 5'd8,
                            32'hFFFD12), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_MAP_BANK, 24'h0, 8'h80, TYPE_OTHER, 16'h1234, 5'd8,
                            32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_TRANSLATE, 24'h80FF, 8'h0, TYPE_NONE, 16'h0, 5'd8,
                            32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_FIND, 24'h0, 8'h0, TYPE_OTHER, 16'h0, 5'd8,
                            32'h123456), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_MAP_BANK, 24'h0, 8'h0, pmm_pkg::TYPE_RAM, 16'hFFFF,
                            5'd16, 32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_TRANSLATE, 24'hFFFF, 8'h0, TYPE_NONE, 16'h0, 5'd8,
                            32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_FIND, 24'h0, 8'h0, pmm_pkg::TYPE_RAM, 16'h0, 5'd8,
                            32'hFFFFFFFF), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_MAP_BANK, 24'h0, 8'h42, TYPE_NONE, 16'h0, 5'd0,
                            32'h0), '0, 1'b0});
    dir_rows.push_back('{mk(pmm_pkg::CMD_TRANSLATE, 24'h4200, 8'h0, TYPE_NONE, 16'h0, 5'd8,
                            32'h0), '0, 1'b0});

    phases.push_back('{5'd24, 5'd22, 5'd19, 0, 0});
    phases.push_back('{5'd8, 5'd8, 5'd8, 82, 0});
    phases.push_back('{5'd0, 5'd31, 5'd0, 0, 82});
    phases.push_back('{5'd20, 5'd12, 5'd31, 7, 7});
    phases.push_back('{5'd31, 5'd5, 5'd19, 0, 0});
    phases.push_back('{5'd16, 5'd17, 5'd14, 82, 0});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 7;
    recv_stall_pct = 7;

    foreach (dir_rows[n]) begin
      @(negedge clk);
      offer(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);
    end

    foreach (phases[p]) begin
      @(negedge clk);
      req_valid <= 1'b0;
      settle();
      write_reg(pmm_pkg::CFG_BUS_WIDTH, phases[p].bus_width);
      write_reg(pmm_pkg::CFG_RAM_SIZE, phases[p].ram_log2);
      write_reg(pmm_pkg::CFG_ROM_SIZE, phases[p].rom_log2);
      if (p == 2) write_reg(pmm_pkg::CFG_NONE, 5'b10101);
      @(negedge clk);
      cfg_valid <= 1'b0;
      send_idle_pct = phases[p].idle_pct;
      recv_stall_pct = phases[p].stall_pct;
      // long hold-off on the result side while items keep coming
      if (p == 0) hold_request = 1'b1;
      repeat (215) begin
        @(negedge clk);
        r = random_item();
        offer(r, 1'b0, '0);
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    settle();
    repeat (10) @(negedge clk);
    if (rsp_due_q.size() != 0) report("results never delivered", rsp_due_q.size(), 0);
    if (mismatches == 0) begin
      $display("[paged_memory_mapper] OK");
    end else begin
      $display("[paged_memory_mapper] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[paged_memory_mapper] ERROR");
    $finish;
  end

endmodule
